FILE: rtl/box_filter_3x3_edge_aware_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the edge-aware 3x3 box filter.
// Both macros sample on aclk and are disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_3X3_EDGE_AWARE_UNIT_MACROS_SVH
`define BOX_FILTER_3X3_EDGE_AWARE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bfe_pkg.sv
// ----------------------------------------------------------------------------
// bfe_pkg
// Shared types and constants of the edge-aware 3x3 box filter.
// ----------------------------------------------------------------------------
package bfe_pkg;

    // Field widths.
    localparam int SAMPLE_W    = 8;
    localparam int ROW_W       = 11;
    localparam int OUT_COL_W   = 11;
    localparam int SMOOTH_W    = 16;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 1;

    // Frame limits. The width compare runs at 13 bits so that a store of
    // up to 4096 columns still fits.
    localparam int WIDTH_CMP_W  = 13;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int DIM_MIN      = 2;
    localparam int DIM_RESET    = 2048;

    // Sum widths: one column of three samples, then three columns.
    localparam int COL_SUM_W = 10;
    localparam int WIN_SUM_W = 12;

    // Constant-reciprocal division of sum*256 by 6 or 9.
    localparam int DIV_X_W     = WIN_SUM_W + 8;
    localparam int RECIP_W     = 22;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP6 = 22'd2796203;
    localparam logic [RECIP_W-1:0] RECIP9 = 22'd1864136;
    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = 16'hFF00;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // One entry of the line store: the two previous rows at one column.
    typedef struct packed {
        sample_t older;
        sample_t newer;
    } line_pair_t;

    // One window column: rows R-2, R-1 and R.
    typedef struct packed {
        sample_t top;
        sample_t mid;
        sample_t bot;
    } win_col_t;

    // Control shared by every window cell.
    typedef struct packed {
        logic shift;
        logic skip_top;
    } cell_ctrl_t;

endpackage

FILE: rtl/bfe_cell.sv
// ----------------------------------------------------------------------------
// bfe_cell
// One column of the 3x3 window. Takes the column of its right neighbor on a
// shift and gives the masked sum of its own three samples.
// ----------------------------------------------------------------------------
module bfe_cell
    import bfe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cell_ctrl_t           ctrl,
    input  win_col_t             col_in,
    output win_col_t             col_out,
    output logic [COL_SUM_W-1:0] col_sum
);

    win_col_t col_reg;
    win_col_t col_next;
    sample_t  top_masked;

    // Shift the neighbor's column in when the window advances.
    assign col_next = ctrl.shift ? col_in : col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    // The top row drops out when it lies above the frame.
    assign top_masked = ctrl.skip_top ? '0 : col_reg.top;
    assign col_sum    = COL_SUM_W'(top_masked) + COL_SUM_W'(col_reg.mid)
                      + COL_SUM_W'(col_reg.bot);
    assign col_out    = col_reg;

endmodule

FILE: rtl/bfe_line_store.sv
// ----------------------------------------------------------------------------
// bfe_line_store
// The two previous rows, stored as pairs at one address per column.
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module bfe_line_store
    import bfe_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic              aclk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output line_pair_t        rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  line_pair_t        wr_data
);

    line_pair_t line_mem [DEPTH];
    line_pair_t rd_data_reg;

    // Entries hold whatever was written last; there is no clearing pass.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/box_filter_3x3_edge_aware_unit.sv
// Flow: a beat passes the load state, then a sum and a divide state for each result, and
// an output stall holds the divide state. The line store read-then-write and the shared
// sum and divide unit mean that a new beat is taken only after the last one is through.
// Reset: width and height return to 2048, row and column to zero, the window to zero.
// The line store is not cleared; rows above the frame are masked out of every sum.
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_aware_unit
// Streaming 3x3 mean filter over a raster of 8-bit samples. The mean covers
// the in-bounds neighborhood only (9, 6 or 4 samples) and is given as an
// unsigned 8.8 value, tagged with its row and column.
// ----------------------------------------------------------------------------
`include "box_filter_3x3_edge_aware_unit_macros.svh"

module box_filter_3x3_edge_aware_unit
    import bfe_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration writes.
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    // Input samples.
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [SAMPLE_W-1:0]  s_sample,
    // Smoothed results.
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ROW_W-1:0]     m_out_row,
    output logic [OUT_COL_W-1:0] m_out_col,
    output logic [SMOOTH_W-1:0]  m_smoothed,
    output logic                 m_frame_last
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SUM,
        ST_DIV
    } state_t;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_t;

    // Control state.
    state_t              state_reg;
    logic [CFG_W-1:0]    width_reg;
    logic [CFG_W-1:0]    height_reg;
    logic [ROW_W-1:0]    row_cnt_reg;
    logic [ADDR_W-1:0]   col_cnt_reg;
    logic [3:0]          pend_reg;
    logic [3:0]          pend_next;
    logic                m_valid_reg;

    // Item and result payload.
    sample_t              smp_reg;
    logic [ROW_W-1:0]     r_reg;
    logic [ADDR_W-1:0]    c_reg;
    logic [WIN_SUM_W-1:0] sum_reg;
    logic [WIN_SUM_W-1:0] sum_next;
    div_t                 div_reg;
    div_t                 div_next;
    logic [ROW_W-1:0]     tag_row_reg;
    logic [OUT_COL_W-1:0] tag_col_reg;
    logic                 tag_last_reg;
    logic [ROW_W-1:0]     m_out_row_reg;
    logic [OUT_COL_W-1:0] m_out_col_reg;
    logic [SMOOTH_W-1:0]  m_smoothed_reg;
    logic                 m_frame_last_reg;

    logic [WIDTH_CMP_W-1:0] w_raw;
    logic [WIDTH_CMP_W-1:0] w_eff;
    logic [CFG_W-1:0]       h_eff;
    logic [ADDR_W-1:0]      c_eff;
    logic [ROW_W-1:0]       r_eff;
    logic                   accept;
    logic                   out_load;
    logic                   last_col;
    logic                   last_row;
    logic                   c_ge1;
    logic                   c_ge2;
    logic                   r_ge1;
    logic                   r_ge2;

    // Selected result.
    logic [3:0]           sel_bit;
    logic                 sel_use_col0;
    logic                 sel_skip_top;
    logic [ROW_W-1:0]     sel_row;
    logic [OUT_COL_W-1:0] sel_col;
    logic                 sel_last;

    line_pair_t               rd_pair;
    line_pair_t               wr_pair;
    win_col_t                 new_col;
    win_col_t                 col1_out;
    win_col_t                 col2_out;
    cell_ctrl_t               cell_ctrl;
    logic [COL_SUM_W-1:0]     cs0;
    logic [COL_SUM_W-1:0]     cs1;
    logic [COL_SUM_W-1:0]     cs2;

    logic [DIV_X_W-1:0]         num;
    logic [RECIP_W-1:0]         recip;
    logic [DIV_X_W+RECIP_W-1:0] prod;
    logic [SMOOTH_W-1:0]        quot;

    // Handshake.
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_DIV) && (!m_valid_reg || m_ready);

    // Clamp the frame size to its usable range.
    assign w_raw = WIDTH_CMP_W'(width_reg);
    always_comb begin
        priority if (w_raw < WIDTH_CMP_W'(DIM_MIN)) begin
            w_eff = WIDTH_CMP_W'(DIM_MIN);
        end else if (w_raw > WIDTH_CMP_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        priority if (height_reg < CFG_W'(DIM_MIN)) begin
            h_eff = CFG_W'(DIM_MIN);
        end else if (height_reg > CFG_W'(HEIGHT_LIMIT)) begin
            h_eff = CFG_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = height_reg;
        end
    end

    // Position of the incoming beat, wrapped if it lies beyond the frame.
    assign c_eff = (WIDTH_CMP_W'(col_cnt_reg) >= w_eff) ? '0 : col_cnt_reg;
    assign r_eff = (CFG_W'(row_cnt_reg) >= h_eff) ? '0 : row_cnt_reg;

    // Geometry of the beat in work.
    assign last_col = (WIDTH_CMP_W'(c_reg) == w_eff - WIDTH_CMP_W'(1));
    assign last_row = (CFG_W'(r_reg) == h_eff - CFG_W'(1));
    assign c_ge1    = (c_reg != '0);
    assign c_ge2    = (WIDTH_CMP_W'(c_reg) >= WIDTH_CMP_W'(2));
    assign r_ge1    = (r_reg != '0);
    assign r_ge2    = (r_reg >= ROW_W'(2));

    // Results that the beat completes, in emission order.
    assign pend_next = {last_row && last_col, last_row && c_ge1,
                        r_ge1 && last_col, r_ge1 && c_ge1};

    // Pick the first pending result and describe its neighborhood.
    always_comb begin
        sel_bit      = '0;
        sel_use_col0 = 1'b0;
        sel_skip_top = 1'b1;
        sel_row      = r_reg;
        sel_col      = OUT_COL_W'(c_reg);
        sel_last     = 1'b0;
        priority if (pend_reg[0]) begin
            sel_bit      = 4'b0001;
            sel_use_col0 = c_ge2;
            sel_skip_top = !r_ge2;
            sel_row      = r_reg - ROW_W'(1);
            sel_col      = OUT_COL_W'(c_reg - ADDR_W'(1));
        end else if (pend_reg[1]) begin
            sel_bit      = 4'b0010;
            sel_skip_top = !r_ge2;
            sel_row      = r_reg - ROW_W'(1);
        end else if (pend_reg[2]) begin
            sel_bit      = 4'b0100;
            sel_use_col0 = c_ge2;
            sel_col      = OUT_COL_W'(c_reg - ADDR_W'(1));
        end else if (pend_reg[3]) begin
            sel_bit      = 4'b1000;
            sel_last     = 1'b1;
        end else begin
            sel_bit      = '0;
        end
    end

    // Line store: read at accept, write back the shifted pair in the next cycle.
    assign wr_pair.older = rd_pair.newer;
    assign wr_pair.newer = smp_reg;

    bfe_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (c_eff),
        .rd_data (rd_pair),
        .wr_en   (state_reg == ST_LOAD),
        .wr_addr (c_reg),
        .wr_data (wr_pair)
    );

    // Window: three cells, the newest column enters at the right end.
    assign new_col.top     = rd_pair.older;
    assign new_col.mid     = rd_pair.newer;
    assign new_col.bot     = smp_reg;
    assign cell_ctrl.shift    = (state_reg == ST_LOAD);
    assign cell_ctrl.skip_top = sel_skip_top;

    bfe_cell u_cell2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cell_ctrl),
        .col_in  (new_col),
        .col_out (col2_out),
        .col_sum (cs2)
    );

    bfe_cell u_cell1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cell_ctrl),
        .col_in  (col2_out),
        .col_out (col1_out),
        .col_sum (cs1)
    );

    bfe_cell u_cell0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (cell_ctrl),
        .col_in  (col1_out),
        .col_out (),
        .col_sum (cs0)
    );

    // Neighborhood sum and the divisor that its size calls for.
    always_comb begin
        sum_next = WIN_SUM_W'(sel_use_col0 ? cs0 : '0) + WIN_SUM_W'(cs1)
                 + WIN_SUM_W'(cs2);
        unique case ({sel_use_col0, sel_skip_top})
            2'b10:   div_next = DIV_BY_9;
            2'b11:   div_next = DIV_BY_6;
            2'b00:   div_next = DIV_BY_6;
            default: div_next = DIV_BY_4;
        endcase
    end

    // sum*256 divided by 4 with a shift, by 6 or 9 with a reciprocal.
    assign num   = {sum_reg, 8'h00};
    assign recip = (div_reg == DIV_BY_9) ? RECIP9 : RECIP6;
    assign prod  = (DIV_X_W+RECIP_W)'(num) * (DIV_X_W+RECIP_W)'(recip);
    always_comb begin
        unique case (div_reg)
            DIV_BY_4: quot = SMOOTH_W'(num >> 2);
            DIV_BY_6: quot = SMOOTH_W'(prod >> RECIP_SHIFT);
            DIV_BY_9: quot = SMOOTH_W'(prod >> RECIP_SHIFT);
            default:  quot = SMOOTH_W'(num >> 2);
        endcase
    end

    // Sequencer, counters, configuration and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            width_reg   <= CFG_W'(DIM_RESET);
            height_reg  <= CFG_W'(DIM_RESET);
            row_cnt_reg <= '0;
            col_cnt_reg <= '0;
            pend_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    pend_reg <= pend_next;
                    if (last_col) begin
                        col_cnt_reg <= '0;
                        row_cnt_reg <= last_row ? '0 : r_reg + ROW_W'(1);
                    end else begin
                        col_cnt_reg <= c_reg + ADDR_W'(1);
                        row_cnt_reg <= r_reg;
                    end
                    state_reg <= (pend_next != '0) ? ST_SUM : ST_IDLE;
                end
                ST_SUM: begin
                    pend_reg  <= pend_reg & ~sel_bit;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (out_load) begin
                        state_reg <= (pend_reg != '0) ? ST_SUM : ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase

            // A register write restarts the frame.
            if (cfg_wr_en) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    width_reg  <= width_reg;
                endcase
                row_cnt_reg <= '0;
                col_cnt_reg <= '0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            smp_reg <= s_sample;
            r_reg   <= r_eff;
            c_reg   <= c_eff;
        end
        if (state_reg == ST_SUM) begin
            sum_reg      <= sum_next;
            div_reg      <= div_next;
            tag_row_reg  <= sel_row;
            tag_col_reg  <= sel_col;
            tag_last_reg <= sel_last;
        end
        if (out_load) begin
            m_out_row_reg    <= tag_row_reg;
            m_out_col_reg    <= tag_col_reg;
            m_smoothed_reg   <= quot;
            m_frame_last_reg <= tag_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_row    = m_out_row_reg;
    assign m_out_col    = m_out_col_reg;
    assign m_smoothed   = m_smoothed_reg;
    assign m_frame_last = m_frame_last_reg;

    // A new beat is taken only when no result of the last one is pending.
    `BFE_ASSERT_NOW(a_idle_no_pend, s_ready, pend_reg == 4'b0000,
        "input ready while results are still pending")
    // An accepted beat goes straight to the line store update.
    `BFE_ASSERT_NEXT(a_accept_load, accept, state_reg == ST_LOAD,
        "accepted beat did not start the window update")
    // Each sum step retires exactly one pending result.
    `BFE_ASSERT_NEXT(a_sum_retires_one, state_reg == ST_SUM,
        $countones(pend_reg) + 1 == $countones($past(pend_reg)),
        "sum step did not retire exactly one result")
    // A mean of 8-bit samples never exceeds 255.0 in 8.8 form.
    `BFE_ASSERT_NOW(a_mean_range, m_valid_reg, m_smoothed_reg <= SMOOTH_MAX,
        "smoothed value out of range")

endmodule

FILE: bench/box_filter_3x3_edge_aware_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_aware_unit_test
// Self-checking bench for the edge-aware 3x3 box filter. Samples go in as
// beats on the input channel. An in-bench filter model computes the row,
// column, 8.8 mean and frame-last flag of every result the block should
// emit. The beats on the result channel are checked against them in order.
// Directed frames cover corners, edges, the interior, register clamping and
// a restart in mid-frame. Random frames and the first beats of two frames
// above the size limits follow. Both sides idle and stall at varying rates.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_aware_unit_test
    import bfe_pkg::*;
();

    localparam int FRAME_COLS    = 2048;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct {
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic [SMOOTH_W-1:0]  mean;
        logic                 last;
    } filtered_pixel_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_wr_en    = 1'b0;
    cfg_reg_t             cfg_index    = REG_WIDTH;
    logic [CFG_W-1:0]     cfg_data     = '0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_sample     = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [ROW_W-1:0]     m_out_row;
    logic [OUT_COL_W-1:0] m_out_col;
    logic [SMOOTH_W-1:0]  m_smoothed;
    logic                 m_frame_last;

    int unsigned send_gap_pct   = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;

    // Filter model state.
    logic [CFG_W-1:0] width_reg  = CFG_W'(DIM_RESET);
    logic [CFG_W-1:0] height_reg = CFG_W'(DIM_RESET);
    sample_t          prev2_row [FRAME_COLS];
    sample_t          prev1_row [FRAME_COLS];
    sample_t          window_px [3][3];
    int               next_row = 0;
    int               next_col = 0;

    filtered_pixel_t  awaited_pixels [$];

    box_filter_3x3_edge_aware_unit #(
        .MAX_WIDTH (FRAME_COLS)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_smoothed   (m_smoothed),
        .m_frame_last (m_frame_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Frame dimension as the block uses it.
    function automatic int clamp_dim(logic [CFG_W-1:0] v, int hi);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    // Mean of the in-bounds part of the window, from column slot first_slot
    // and window row first_line on, queued as one expected result.
    function automatic void queue_mean(int row, int col, int first_slot, int first_line,
                                       logic last);
        filtered_pixel_t px;
        int unsigned     total;
        int unsigned     count;
        total = 0;
        count = 0;
        for (int s = first_slot; s <= 2; s++) begin
            for (int r = first_line; r <= 2; r++) begin
                total += window_px[s][r];
                count++;
            end
        end
        px.row  = ROW_W'(row);
        px.col  = OUT_COL_W'(col);
        px.mean = SMOOTH_W'((total * 256) / count);
        px.last = last;
        awaited_pixels.push_back(px);
    endfunction

    // Takes one accepted sample through the filter model.
    function automatic void smooth_sample(sample_t smp);
        int  w;
        int  h;
        int  r;
        int  c;
        int  top_line;
        int  left_slot;
        bit  last_col;
        bit  last_row;
        w = clamp_dim(width_reg, FRAME_COLS);
        h = clamp_dim(height_reg, HEIGHT_LIMIT);
        r = next_row;
        c = next_col;
        if (c >= w) c = 0;
        if (r >= h) r = 0;

        // Shift the window left and load the new column.
        for (int s = 0; s < 2; s++) window_px[s] = window_px[s + 1];
        window_px[2][0] = prev2_row[c];
        window_px[2][1] = prev1_row[c];
        window_px[2][2] = smp;
        prev2_row[c]    = prev1_row[c];
        prev1_row[c]    = smp;

        last_col  = (c == w - 1);
        last_row  = (r == h - 1);
        top_line  = (r >= 2) ? 0 : 1;
        left_slot = (c >= 2) ? 0 : 1;

        // Every result whose neighborhood this sample completes.
        if (r >= 1 && c >= 1) queue_mean(r - 1, c - 1, left_slot, top_line, 1'b0);
        if (r >= 1 && last_col) queue_mean(r - 1, c, 1, top_line, 1'b0);
        if (last_row && c >= 1) queue_mean(r, c - 1, left_slot, 1, 1'b0);
        if (last_row && last_col) queue_mean(r, c, 1, 1, 1'b1);

        if (last_col) begin
            c = 0;
            r = last_row ? 0 : r + 1;
        end else begin
            c++;
        end
        next_row = r;
        next_col = c;
    endfunction

    // One register write; any write restarts the frame.
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        if (idx == REG_WIDTH) width_reg = val;
        else height_reg = val;
        next_row = 0;
        next_col = 0;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic start_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    // Offers one sample beat, with random idle cycles ahead of it.
    task automatic send_sample(input sample_t smp);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        smooth_sample(smp);
    endtask

    // Stops the input and lets every awaited result arrive, then gives the
    // block time to finish samples that cause no result.
    task automatic wait_filter_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (awaited_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic sample_t random_sample();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 10) return '0;
        if (pick < 20) return '1;
        return sample_t'($urandom_range(255));
    endfunction

    // Smallest frame at full scale: every result is 255.0.
    task automatic test_smallest_frame();
        start_frame(2, 2);
        repeat (4) send_sample(8'd255);
        wait_filter_idle();
    endtask

    // 3x3 frame: its corners, its edges and its center position.
    task automatic test_neighborhood_sizes();
        sample_t px [9];
        px = '{8'd0, 8'd255, 8'd17, 8'd200, 8'd255, 8'd0, 8'd90, 8'd1, 8'd128};
        start_frame(3, 3);
        foreach (px[i]) send_sample(px[i]);
        wait_filter_idle();
    endtask

    // Dimensions below the minimum act as 2.
    task automatic test_clamped_low();
        start_frame(1, 0);
        send_sample(8'd0);
        send_sample(8'd255);
        send_sample(8'd255);
        send_sample(8'd3);
        wait_filter_idle();
    endtask

    // A single register write in mid-frame sends the block back to row 0.
    task automatic test_restart_mid_frame();
        start_frame(3, 2);
        send_sample(8'd40);
        send_sample(8'd250);
        wait_filter_idle();
        write_reg(REG_WIDTH, 3);
        repeat (6) send_sample(random_sample());
        wait_filter_idle();
    endtask

    // Width above the limit: the start of a first row, which completes no result.
    task automatic test_widest_row();
        start_frame(4095, 2);
        repeat (24) send_sample(random_sample());
        wait_filter_idle();
    endtask

    // Height above the limit: the first rows of a tall, narrow frame.
    task automatic test_tallest_frame();
        start_frame(2, 4095);
        repeat (48) send_sample(random_sample());
        wait_filter_idle();
    endtask

    // Mostly whole small frames, some back to back; the rest are cut short,
    // clamped low, or far too wide to finish a row.
    task automatic test_random_frames(input int unsigned budget);
        int unsigned sent;
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        int unsigned beats;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
                w     = $urandom_range(9, 2);
                h     = $urandom_range(7, 2);
                beats = w * h * $urandom_range(2, 1);
            end else if (pick < 80) begin
                w     = $urandom_range(1, 0);
                h     = $urandom_range(1, 0);
                beats = 4 * $urandom_range(2, 1);
            end else if (pick < 92) begin
                w     = $urandom_range(9, 2);
                h     = $urandom_range(7, 2);
                beats = $urandom_range(w * h - 1, 1);
            end else begin
                w     = ($urandom_range(1) == 0) ? FRAME_COLS : $urandom_range(4095, 2049);
                h     = $urandom_range(4095, 2);
                beats = $urandom_range(20, 1);
            end
            // The last frame of the budget may be cut short.
            if (beats > budget - sent) begin
                beats = budget - sent;
            end
            start_frame(CFG_W'(w), CFG_W'(h));
            repeat (beats) send_sample(random_sample());
            wait_filter_idle();
            sent += beats;
        end
    endtask

    // Result side: random stalls.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Each result beat against the oldest expectation.
    always @(posedge aclk) begin : check_results
        filtered_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_pixels.size() == 0) begin
                $error("unexpected result at row %0d, column %0d", m_out_row, m_out_col);
                mismatch_count++;
            end else begin
                want = awaited_pixels.pop_front();
                if (m_out_row !== want.row) begin
                    $error("out_row: expected %0d, actual %0d", want.row, m_out_row);
                    mismatch_count++;
                end
                if (m_out_col !== want.col) begin
                    $error("out_col: expected %0d, actual %0d", want.col, m_out_col);
                    mismatch_count++;
                end
                if (m_smoothed !== want.mean) begin
                    $error("smoothed: expected 0x%04h, actual 0x%04h", want.mean, m_smoothed);
                    mismatch_count++;
                end
                if (m_frame_last !== want.last) begin
                    $error("frame_last: expected %0b, actual %0b", want.last, m_frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when no beat and no write has happened for too long.
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Slow sender, heavily stalled receiver.
        send_gap_pct   = 16;
        recv_stall_pct = 71;
        test_smallest_frame();
        test_neighborhood_sizes();
        test_clamped_low();
        test_restart_mid_frame();
        test_random_frames(105);

        // Bursty receiver, sparse sender.
        send_gap_pct   = 71;
        recv_stall_pct = 16;
        test_random_frames(105);

        // Full rate on both sides.
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_widest_row();
        test_tallest_frame();
        test_random_frames(105);

        if (mismatch_count == 0 && awaited_pixels.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
